@@ rtl/gpz_pkg.sv @@
// Package for the GF(4) zero-count screen: field widths, lane count,
// GF(4) product and bilinear vector product. No dependencies.
`timescale 1ns / 1ps
package gpz_pkg;

	localparam int DIGIT_W      = 54;
	localparam int ELEMS        = DIGIT_W / 2;
	localparam int INDEX_W      = 12;
	localparam int CFG_W        = 13;
	localparam int COUNT_OUT_W  = 13;
	localparam int COUNT_MAX    = 8191;
	localparam int LANES        = 16;
	localparam int LANE_W       = 4;
	localparam int DEF_NUM_POINTS = 4096;
	localparam int DEF_DIMENSION  = 27;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	// x*y in GF(4), coded bit0 + bit1*w, w^2 = w + 1
	function automatic logic [1:0] gf4_mul(input logic [1:0] x, input logic [1:0] y);
		logic lo;
		logic hi;
		lo = (x[0] & y[0]) ^ (x[1] & y[1]);
		hi = (x[0] & y[1]) ^ (x[1] & y[0]) ^ (x[1] & y[1]);
		return {hi, lo};
	endfunction

	// sum over elements below dim of u_c*p_c; sums are XOR
	function automatic logic [1:0] gf4_dot(input logic [DIGIT_W-1:0] u,
			input logic [DIGIT_W-1:0] p, input int dim);
		logic [1:0] acc;
		acc = 2'b00;
		for (int c = 0; c < ELEMS; c++) begin
			if (c < dim) begin
				acc = acc ^ gf4_mul(u[2*c +: 2], p[2*c +: 2]);
			end
		end
		return acc;
	endfunction

endpackage

@@ rtl/gpz_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module gpz_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/gf4_point_set_zero_count.sv @@
// GF(4) zero-count screen, top level: 16 point banks, scan sequencer,
// per-lane dot product and count accumulator. Uses gpz_pkg and gpz_ram.
//
// Usage: a beat is taken on start while busy is low. req_type selects the beat:
//   load  - writes point_digits at point_index (ignored when the index is at or
//           above NUM_POINTS). busy never rises, no result.
//   query - counts the first points_in_use stored points (capped at NUM_POINTS)
//           whose GF(4) product with query_digits is zero.
// Points sit in 16 banks, point i in bank i%16 at row i/16, so one row read
// checks 16 points. A query reads the rows that hold the scanned points, one
// row per cycle through the single read port of each bank, then drains its
// read and flag stages before the done strobe; busy is high throughout.
// The result is on zero_count for the one cycle that done is high; the
// receiver cannot stall it. The count saturates at 8191.
// points_in_use must be written via cfg_we/cfg_wdata while idle (unenforced).
// Reset clears the sequencer and points_in_use; the point table is not
// cleared and entries must be loaded before a query scans them.
`timescale 1ns / 1ps
module gf4_point_set_zero_count
	import gpz_pkg::*;
#(
	parameter int NUM_POINTS = DEF_NUM_POINTS,
	parameter int DIMENSION  = DEF_DIMENSION
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   req_type,
	input  logic [INDEX_W-1:0]     point_index,
	input  logic [DIGIT_W-1:0]     point_digits,
	input  logic [DIGIT_W-1:0]     query_digits,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,
	output logic                   done,
	output logic [COUNT_OUT_W-1:0] zero_count
);

	localparam int ROWS  = (NUM_POINTS + LANES - 1) / LANES;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RC_W  = $clog2(ROWS + 1);
	localparam int CNT_W = $clog2(NUM_POINTS + 1);
	localparam int RN_W  = CNT_W + LANE_W;
	localparam int IW    = (RW + LANE_W > CNT_W) ? RW + LANE_W : CNT_W;
	localparam int SAT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0]   points_in_use_q;
	logic [CNT_W-1:0]   scan_q;
	logic [RC_W-1:0]    rows_q;
	logic [RC_W-1:0]    row_q;
	logic [DIGIT_W-1:0] query_q;
	logic               rd_s1;
	logic [RW-1:0]      row_s1;
	logic               flg_v_s2;
	logic [LANES-1:0]   flags_s2;
	logic [CNT_W-1:0]   cnt_q;

	logic               load_fire;
	logic               query_fire;
	logic               load_in_range;
	logic               issue;
	logic [RW-1:0]      wr_row;
	logic [RW-1:0]      rd_row;
	logic [CNT_W-1:0]   scan_len;
	logic [RN_W-1:0]    rows_need;
	logic [LANES-1:0]   flags;
	logic [LANE_W:0]    hits;
	logic [SAT_W-1:0]   cnt_ext;
	logic [DIGIT_W-1:0] rd_data [LANES];

	assign busy          = (state_q != ST_IDLE);
	assign load_fire     = start && !busy && (req_type == REQ_LOAD);
	assign query_fire    = start && !busy && (req_type == REQ_QUERY);
	assign load_in_range = (32'(point_index) < NUM_POINTS);
	assign wr_row        = RW'(point_index >> LANE_W);
	assign issue         = (state_q == ST_SCAN);
	assign rd_row        = row_q[RW-1:0];

	always_comb begin
		if (32'(points_in_use_q) > NUM_POINTS) begin
			scan_len = CNT_W'(NUM_POINTS);
		end else begin
			scan_len = CNT_W'(points_in_use_q);
		end
		rows_need = (RN_W'(scan_len) + RN_W'(LANES - 1)) >> LANE_W;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_bank
		gpz_ram #(
			.WIDTH(DIGIT_W),
			.DEPTH(ROWS)
		) u_bank (
			.clk    (clk),
			.wr_en  (load_fire && load_in_range && (point_index[LANE_W-1:0] == LANE_W'(l))),
			.wr_addr(wr_row),
			.wr_data(point_digits),
			.rd_en  (issue),
			.rd_addr(rd_row),
			.rd_data(rd_data[l])
		);
	end

	// lanes past the scan length are masked off
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			flags[l] = (gf4_dot(query_q, rd_data[l], DIMENSION) == 2'b00) &&
				(((IW'(row_s1) << LANE_W) | IW'(l)) < IW'(scan_q));
		end
		hits    = (LANE_W + 1)'($countones(flags_s2));
		cnt_ext = SAT_W'(cnt_q);
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			query_q <= query_digits;
			scan_q  <= scan_len;
		end
		row_s1   <= rd_row;
		flags_s2 <= flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			points_in_use_q <= '0;
			rows_q          <= '0;
			row_q           <= '0;
			rd_s1           <= 1'b0;
			flg_v_s2        <= 1'b0;
			cnt_q           <= '0;
			done            <= 1'b0;
			zero_count      <= '0;
		end else begin
			done     <= (state_q == ST_DRAIN) && !rd_s1 && !flg_v_s2;
			rd_s1    <= issue;
			flg_v_s2 <= rd_s1;
			if (cfg_we) begin
				points_in_use_q <= cfg_wdata;
			end
			if (flg_v_s2) begin
				cnt_q <= cnt_q + CNT_W'(hits);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_fire) begin
						rows_q <= RC_W'(rows_need);
						row_q  <= '0;
						cnt_q  <= '0;
						if (rows_need == '0) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					row_q <= row_q + 1'b1;
					if (row_q == rows_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_s1 && !flg_v_s2) begin
						state_q <= ST_IDLE;
						if (cnt_ext > SAT_W'(COUNT_MAX)) begin
							zero_count <= COUNT_OUT_W'(COUNT_MAX);
						end else begin
							zero_count <= COUNT_OUT_W'(cnt_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
